// ===== sv/chm_pkg.sv =====
package chm_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // request held steady for the whole walk down the chain
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } chm_req_t;

    // token that walks one cell per cycle
    typedef struct packed {
        logic             active;
        logic             hit;
        logic [VAL_W-1:0] value;
    } chm_tok_t;

endpackage

// ===== sv/chm_req_if.sv =====
interface chm_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [chm_pkg::KEY_W-1:0] key_handle;
    logic [chm_pkg::VAL_W-1:0] new_value;

    modport source (output valid, output req_type, output key_handle, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input key_handle, input new_value,
                    output ready);
endinterface

// ===== sv/chm_rsp_if.sv =====
interface chm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [chm_pkg::VAL_W-1:0] value_out;
    logic [1:0]                status;

    modport source (output valid, output value_out, output status, input ready);
    modport sink   (input valid, input value_out, input status, output ready);
endinterface

// ===== sv/chm_cell.sv =====
module chm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  chm_pkg::chm_req_t         req,
    input  chm_pkg::chm_tok_t         tok_in,
    output chm_pkg::chm_tok_t         tok_out,
    input  logic [chm_pkg::KEY_W-1:0] next_key,
    input  logic [chm_pkg::VAL_W-1:0] next_val,
    output logic [chm_pkg::KEY_W-1:0] key_out,
    output logic [chm_pkg::VAL_W-1:0] val_out
);

    logic [chm_pkg::KEY_W-1:0] key_reg, key_next;
    logic [chm_pkg::VAL_W-1:0] val_reg, val_next;
    chm_pkg::chm_tok_t         tok_reg, tok_next;

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        tok_next = tok_in;
        if (tok_in.active)
        begin
            if (!tok_in.hit)
            begin
                unique case (req.op)
                    chm_pkg::REQ_INSERT:
                    begin
                        if (key_reg == '0)
                        begin
                            key_next     = req.key;
                            val_next     = req.value;
                            tok_next.hit = 1'b1;
                        end
                    end
                    chm_pkg::REQ_LOOKUP:
                    begin
                        if (key_reg == req.key)
                        begin
                            tok_next.hit   = 1'b1;
                            tok_next.value = val_reg;
                        end
                    end
                    chm_pkg::REQ_DELETE:
                    begin
                        if (key_reg == req.key)
                        begin
                            tok_next.hit   = 1'b1;
                            tok_next.value = val_reg;
                            key_next       = next_key;
                            val_next       = next_val;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (req.op == chm_pkg::REQ_DELETE)
            begin
                // upper neighbor is still untouched: the token reaches it next cycle
                key_next = next_key;
                val_next = next_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;
    assign val_out = val_reg;

endmodule

// ===== sv/compacting_handle_map.sv =====
// Channel  Role    Words
// req      sink    req_type, key_handle, new_value
// rsp      source  value_out, status
//
// Insert, lookup and delete of a nonzero key send a token through the row of
// TABLE_DEPTH cells, one cell per cycle; the result then passes the pending
// register into the output register. Key zero and unused request codes are
// answered straight from the output register. One request is in the row at
// a time. Reset clears all keys (table empty) at once. A stall on rsp holds
// the result in the output register and keeps req from taking the next word.
module compacting_handle_map #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp
);

    chm_pkg::chm_req_t req_reg;
    logic              launch_reg;
    logic              busy_reg;
    logic              pend_valid_reg;
    logic [chm_pkg::VAL_W-1:0] pend_value_reg;
    logic [1:0]                pend_status_reg;
    logic                      out_valid_reg;
    logic [chm_pkg::VAL_W-1:0] out_value_reg;
    logic [1:0]                out_status_reg;

    chm_pkg::chm_tok_t         tok [TABLE_DEPTH+1];
    logic [chm_pkg::KEY_W-1:0] keys [TABLE_DEPTH+1];
    logic [chm_pkg::VAL_W-1:0] vals [TABLE_DEPTH+1];

    logic       take;
    logic       out_free;
    logic       walk;
    logic [1:0] quick_status;
    logic [1:0] fin_status;
    logic [chm_pkg::VAL_W-1:0] fin_value;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && out_free;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        walk         = 1'b0;
        quick_status = chm_pkg::ST_NOT_FOUND;
        if (req.req_type == chm_pkg::REQ_INSERT && req.key_handle == '0)
            quick_status = chm_pkg::ST_OK;
        else if ((req.req_type == chm_pkg::REQ_INSERT || req.req_type == chm_pkg::REQ_LOOKUP
                  || req.req_type == chm_pkg::REQ_DELETE) && req.key_handle != '0)
            walk = 1'b1;
    end

    assign tok[0]            = '{active: launch_reg, hit: 1'b0, value: '0};
    assign keys[TABLE_DEPTH] = '0;
    assign vals[TABLE_DEPTH] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        chm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .next_key (keys[i+1]),
            .next_val (vals[i+1]),
            .key_out  (keys[i]),
            .val_out  (vals[i])
        );
    end

    always_comb
    begin
        fin_value  = '0;
        fin_status = chm_pkg::ST_NOT_FOUND;
        if (req_reg.op == chm_pkg::REQ_INSERT)
            fin_status = tok[TABLE_DEPTH].hit ? chm_pkg::ST_OK : chm_pkg::ST_FULL;
        else if (tok[TABLE_DEPTH].hit)
        begin
            fin_status = chm_pkg::ST_OK;
            fin_value  = tok[TABLE_DEPTH].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            launch_reg <= take && walk;
            if (take && walk)
                busy_reg <= 1'b1;
            if (tok[TABLE_DEPTH].active)
                pend_valid_reg <= 1'b1;
            if (out_free)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                    busy_reg       <= 1'b0;
                end
                else
                    out_valid_reg <= take && !walk;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.op    <= req.req_type;
            req_reg.key   <= req.key_handle;
            req_reg.value <= req.new_value;
        end
        if (tok[TABLE_DEPTH].active)
        begin
            pend_value_reg  <= fin_value;
            pend_status_reg <= fin_status;
        end
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_value_reg  <= pend_value_reg;
                out_status_reg <= pend_status_reg;
            end
            else
            begin
                out_value_reg  <= '0;
                out_status_reg <= quick_status;
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.status    = out_status_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;

    localparam int DEPTH = 32;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1500;
    localparam int POOL_SIZE = 12;
    // longest correct quiet spell is the long rsp hold-off plus one walk
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [chm_pkg::VAL_W-1:0] value;
        logic [1:0]                status;
    } reply_t;

    // Shadow copy of the table; predicts one reply per accepted request.
    class handle_table_checker;
        logic [chm_pkg::KEY_W-1:0] keys [DEPTH];
        logic [chm_pkg::VAL_W-1:0] vals [DEPTH];
        int                        used;
        reply_t                    expected_replies [$];
        int                        mismatches;

        function new();
            foreach (keys[i])
            begin
                keys[i] = '0;
                vals[i] = '0;
            end
            used = 0;
            mismatches = 0;
        endfunction

        function reply_t predict_reply(logic [1:0] op, logic [chm_pkg::KEY_W-1:0] key,
                                       logic [chm_pkg::VAL_W-1:0] value);
            reply_t r;
            int     slot;
            int     i;
            r.value = '0;
            r.status = chm_pkg::ST_NOT_FOUND;
            slot = DEPTH;
            for (i = used - 1; i >= 0; i--)
            begin
                if (keys[i] == key)
                    slot = i;
            end
            case (op) inside
                chm_pkg::REQ_INSERT:
                begin
                    if (key == '0)
                        r.status = chm_pkg::ST_OK;
                    else if (used >= DEPTH)
                        r.status = chm_pkg::ST_FULL;
                    else
                    begin
                        keys[used] = key;
                        vals[used] = value;
                        used++;
                        r.status = chm_pkg::ST_OK;
                    end
                end
                chm_pkg::REQ_LOOKUP, chm_pkg::REQ_DELETE:
                begin
                    if (key != '0 && slot < DEPTH)
                    begin
                        r.value = vals[slot];
                        r.status = chm_pkg::ST_OK;
                        if (op == chm_pkg::REQ_DELETE)
                        begin
                            for (i = slot; i < DEPTH - 1; i++)
                            begin
                                keys[i] = keys[i + 1];
                                vals[i] = vals[i + 1];
                            end
                            keys[DEPTH - 1] = '0;
                            vals[DEPTH - 1] = '0;
                            used--;
                        end
                    end
                end
                default: ;  // unused code: table untouched, not-found
            endcase
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [chm_pkg::KEY_W-1:0] key,
                                   logic [chm_pkg::VAL_W-1:0] value);
            expected_replies.push_back(predict_reply(op, key, value));
        endfunction

        function void check_reply(logic [chm_pkg::VAL_W-1:0] value, logic [1:0] status);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected word: value %h status %0d", $time, value, status);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: value_out expected %h got %h", $time, want.value, value);
                mismatches++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    chm_req_if req_ch ();
    chm_rsp_if rsp_ch ();

    handle_table_checker book;

    compacting_handle_map #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one word and returns at the edge where it is taken; valid stays up.
    task automatic send_word(input logic [1:0] op, input logic [chm_pkg::KEY_W-1:0] key,
                             input logic [chm_pkg::VAL_W-1:0] value, input bit may_idle);
        if (may_idle && $urandom_range(99) < 29)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= op;
        req_ch.key_handle <= key;
        req_ch.new_value  <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request(op, key, value);
    endtask

    initial
    begin
        logic [chm_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [1:0]                op;
        logic [chm_pkg::KEY_W-1:0] key;
        logic [chm_pkg::VAL_W-1:0] value;
        int                        roll;
        bit                        filling;

        book = new();
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= chm_pkg::REQ_INSERT;
        req_ch.key_handle <= '0;
        req_ch.new_value  <= '0;
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            key_pool[i] = $urandom | 32'h1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // misses on an empty table, key zero, unused code
        send_word(chm_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h0000_0000, 32'h0, 1);
        send_word(REQ_UNUSED, 32'h0000_0005, 32'h5, 1);
        // extremes, stored zero value, duplicates
        send_word(chm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_word(chm_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0000, 1);
        send_word(chm_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_1234, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_INSERT, 32'h8000_0000, 32'h5555_5555, 1);
        send_word(chm_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1);
        // delete from the bottom slot, then from the top used slot
        send_word(chm_pkg::REQ_DELETE, 32'hFFFF_FFFF, 32'h0, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h7FFF_FFFF, 32'h0, 1);
        send_word(chm_pkg::REQ_LOOKUP, 32'hDEAD_BEEF, 32'h0, 1);
        send_word(REQ_UNUSED, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h0000_0001, 32'h0, 1);
        send_word(chm_pkg::REQ_DELETE, 32'h8000_0000, 32'h0, 1);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // alternate fill and drain phases so the table hits full and empty
            filling = (n % 240) < 120;
            if (n == 1100)
            begin
                req_ch.valid <= 1'b0;
                while (book.expected_replies.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            roll = $urandom_range(99);
            if (filling)
                op = roll < 65 ? chm_pkg::REQ_INSERT : roll < 80 ? chm_pkg::REQ_LOOKUP :
                     roll < 95 ? chm_pkg::REQ_DELETE : REQ_UNUSED;
            else
                op = roll < 15 ? chm_pkg::REQ_INSERT : roll < 40 ? chm_pkg::REQ_LOOKUP :
                     roll < 95 ? chm_pkg::REQ_DELETE : REQ_UNUSED;
            roll = $urandom_range(99);
            key = roll < 75 ? key_pool[$urandom_range(POOL_SIZE - 1)] :
                  roll < 93 ? $urandom : '0;
            roll = $urandom_range(99);
            value = roll < 10 ? '0 : roll < 20 ? '1 : $urandom;
            send_word(op, key, value, !(n >= 300 && n < 600));
        end

        req_ch.valid <= 1'b0;
        while (book.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
        if (book.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // result side: random stalls, a stall-free stretch, one long hold-off
    initial
    begin
        int taken;
        int hold;
        taken = 0;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                book.check_reply(rsp_ch.value_out, rsp_ch.status);
                taken++;
                if (taken == 900)
                    hold = 400;
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else if (taken >= 300 && taken < 600)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 29);
            @(posedge clk);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== compacting_handle_map.f =====
sv/chm_pkg.sv
sv/chm_req_if.sv
sv/chm_rsp_if.sv
sv/chm_cell.sv
sv/compacting_handle_map.sv
bench/tb.sv
